// File: src/c_escape_sequence_decoder_unit_macros.svh
// Assertion macros for the C escape sequence decoder.
// No dependencies; included by files that carry concurrent checks.
`ifndef C_ESCAPE_SEQUENCE_DECODER_UNIT_MACROS_SVH
`define C_ESCAPE_SEQUENCE_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CESD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("escape decoder check failed");

// Next-cycle implication, checked outside reset.
`define CESD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("escape decoder check failed");

`endif

// File: src/esc_dec_pkg.sv
// Package for the C escape sequence decoder: beat types, status codes,
// character classification helpers. No dependencies.
`timescale 1ns / 1ps

package esc_dec_pkg;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_OCT_RANGE = 2'd1;
   localparam logic [1:0] ST_BAD_HEX   = 2'd2;
   localparam logic [1:0] ST_END       = 2'd3;

   localparam logic [2:0] USED_NONE  = 3'd0;
   localparam logic [2:0] USED_ONE   = 3'd2;
   localparam logic [2:0] USED_TWO   = 3'd3;
   localparam logic [2:0] USED_THREE = 3'd4;

   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_X   = "x";

   typedef struct packed {
      logic [7:0] first_char;
      logic [7:0] second_char;
      logic [7:0] third_char;
   } req_type;

   typedef struct packed {
      logic [7:0] decoded_byte;
      logic [2:0] consumed;
      logic [1:0] status;
   } rsp_type;

   function automatic logic is_oct(input logic [7:0] c);
      return c inside {["0":"7"]};
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return c inside {["0":"9"], ["a":"f"], ["A":"F"]};
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] v;
      v = 8'd0;
      if (c inside {["0":"9"]}) begin
         v = c - 8'h30;
      end else if (c inside {["a":"f"]}) begin
         v = c - 8'h57;
      end else if (c inside {["A":"F"]}) begin
         v = c - 8'h37;
      end
      return v[3:0];
   endfunction

   function automatic logic [7:0] named_val(input logic [7:0] c);
      logic [7:0] v;
      case (c)
         "n":     v = 8'd10;
         "r":     v = 8'd13;
         "a":     v = 8'd7;
         "b":     v = 8'd8;
         "f":     v = 8'd12;
         "t":     v = 8'd9;
         "v":     v = 8'd11;
         default: v = c;
      endcase
      return v;
   endfunction

endpackage

// File: src/c_escape_sequence_decoder_unit.sv
// Decodes the escape that follows a backslash: classify, assemble, select.
// Depends on esc_dec_pkg and c_escape_sequence_decoder_unit_macros.svh.
//
// One sequence is taken per cycle while req_ready is high. A request beat accepted
// at a clock edge passes through three register stages before rsp_data shows its
// result. The stages are character classify, octal and hex value assembly, and
// final select into the output register. Each stage advances whenever the stage
// after it is empty or moving, so bubbles close up while a result waits.
// req_ready drops only once all three stages hold beats and rsp_ready is low.
`timescale 1ns / 1ps
`include "c_escape_sequence_decoder_unit_macros.svh"

module c_escape_sequence_decoder_unit
   import esc_dec_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef struct packed {
      logic       c1_oct;
      logic       c2_oct;
      logic       c3_oct;
      logic       c1_x;
      logic       c1_zero;
      logic       c2_hex;
      logic       c3_hex;
      logic [2:0] d1;
      logic [2:0] d2;
      logic [2:0] d3;
      logic [3:0] h2;
      logic [3:0] h3;
      logic [7:0] other_val;
   } s1_type;

   typedef struct packed {
      logic       c1_oct;
      logic       c1_x;
      logic       c1_zero;
      logic       oct_range;
      logic [7:0] oct_val;
      logic [2:0] oct_used;
      logic       hex_bad;
      logic [7:0] hex_val;
      logic [2:0] hex_used;
      logic [7:0] other_val;
   } s2_type;

   logic    v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic    en1, en2, en3;
   s1_type  s1_ff, s1_in;
   s2_type  s2_ff, s2_in;
   rsp_type rsp_ff, rsp_in;

   assign en3       = !v3_ff || rsp_ready;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_ready = en1;
   assign rsp_valid = v3_ff;
   assign rsp_data  = rsp_ff;

   assign v1_in = en1 ? req_valid : v1_ff;
   assign v2_in = en2 ? v1_ff : v2_ff;
   assign v3_in = en3 ? v2_ff : v3_ff;

   // classify
   always_comb begin
      s1_in.c1_oct    = is_oct(req_data.first_char);
      s1_in.c2_oct    = is_oct(req_data.second_char);
      s1_in.c3_oct    = is_oct(req_data.third_char);
      s1_in.c1_x      = (req_data.first_char == CH_X);
      s1_in.c1_zero   = (req_data.first_char == CH_NUL);
      s1_in.c2_hex    = is_hex(req_data.second_char);
      s1_in.c3_hex    = is_hex(req_data.third_char);
      s1_in.d1        = req_data.first_char[2:0];
      s1_in.d2        = req_data.second_char[2:0];
      s1_in.d3        = req_data.third_char[2:0];
      s1_in.h2        = hex_val(req_data.second_char);
      s1_in.h3        = hex_val(req_data.third_char);
      s1_in.other_val = named_val(req_data.first_char);
   end

   // assemble octal and hex values
   always_comb begin
      s2_in.c1_oct    = s1_ff.c1_oct;
      s2_in.c1_x      = s1_ff.c1_x;
      s2_in.c1_zero   = s1_ff.c1_zero;
      s2_in.other_val = s1_ff.other_val;
      s2_in.oct_range = 1'b0;
      if (s1_ff.c2_oct && s1_ff.c3_oct) begin
         s2_in.oct_range = s1_ff.d1[2];
         s2_in.oct_val   = {s1_ff.d1[1:0], s1_ff.d2, s1_ff.d3};
         s2_in.oct_used  = USED_THREE;
      end else if (s1_ff.c2_oct) begin
         s2_in.oct_val   = {2'b00, s1_ff.d1, s1_ff.d2};
         s2_in.oct_used  = USED_TWO;
      end else begin
         s2_in.oct_val   = {5'd0, s1_ff.d1};
         s2_in.oct_used  = USED_ONE;
      end
      s2_in.hex_bad = !s1_ff.c2_hex;
      if (s1_ff.c3_hex) begin
         s2_in.hex_val  = {s1_ff.h2, s1_ff.h3};
         s2_in.hex_used = USED_THREE;
      end else begin
         s2_in.hex_val  = {4'd0, s1_ff.h2};
         s2_in.hex_used = USED_TWO;
      end
   end

   // select
   always_comb begin
      rsp_in.decoded_byte = 8'd0;
      rsp_in.consumed     = USED_NONE;
      rsp_in.status       = ST_OK;
      if (s2_ff.c1_oct) begin
         if (s2_ff.oct_range) begin
            rsp_in.status = ST_OCT_RANGE;
         end else begin
            rsp_in.decoded_byte = s2_ff.oct_val;
            rsp_in.consumed     = s2_ff.oct_used;
         end
      end else if (s2_ff.c1_x) begin
         if (s2_ff.hex_bad) begin
            rsp_in.status = ST_BAD_HEX;
         end else begin
            rsp_in.decoded_byte = s2_ff.hex_val;
            rsp_in.consumed     = s2_ff.hex_used;
         end
      end else if (s2_ff.c1_zero) begin
         rsp_in.status = ST_END;
      end else begin
         rsp_in.decoded_byte = s2_ff.other_val;
         rsp_in.consumed     = USED_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_ff <= s1_in;
      end
      if (en2) begin
         s2_ff <= s2_in;
      end
      if (en3) begin
         rsp_ff <= rsp_in;
      end
   end

   `CESD_ASSERT_NEXT(a_s1_hold, clock, reset, v1_ff && !en1, v1_ff && $stable(s1_ff))
   `CESD_ASSERT_IMPL(a_empty_out_ready, clock, reset, !v3_ff, req_ready)
   `CESD_ASSERT_IMPL(a_err_zero, clock, reset, v3_ff && (rsp_ff.status != ST_OK), (rsp_ff.decoded_byte == 8'd0) && (rsp_ff.consumed == USED_NONE))
   `CESD_ASSERT_IMPL(a_ok_used, clock, reset, v3_ff && (rsp_ff.status == ST_OK), (rsp_ff.consumed == USED_ONE) || (rsp_ff.consumed == USED_TWO) || (rsp_ff.consumed == USED_THREE))

endmodule

// File: dv/c_escape_sequence_decoder_checker.sv
// Checker for the C escape sequence decoder: watches both channels, predicts each
// result from its request beat and compares field by field. Depends on esc_dec_pkg.
`timescale 1ns / 1ps

module esc_dec_checker
   import esc_dec_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      results_due
);

   rsp_type expected_q[$];

   initial begin
      fail_count = 0;
      results_due = 0;
   end

   function automatic logic octal_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "7");
   endfunction

   function automatic logic hex_digit(input logic [7:0] c);
      return ((c >= "0") && (c <= "9")) || ((c >= "a") && (c <= "f")) ||
             ((c >= "A") && (c <= "F"));
   endfunction

   function automatic logic [3:0] hex_weight(input logic [7:0] c);
      logic [7:0] w;
      if ((c >= "0") && (c <= "9")) begin
         w = c - "0";
      end else if ((c >= "a") && (c <= "f")) begin
         w = c - "a" + 8'd10;
      end else begin
         w = c - "A" + 8'd10;
      end
      return w[3:0];
   endfunction

   function automatic rsp_type decode_escape(input req_type r);
      rsp_type    o;
      logic [8:0] oct_value;
      o.decoded_byte = 8'd0;
      o.consumed = USED_NONE;
      o.status = ST_OK;
      oct_value = {r.first_char[2:0], r.second_char[2:0], r.third_char[2:0]};
      if (octal_digit(r.first_char)) begin
         if (!octal_digit(r.second_char)) begin
            o.decoded_byte = {5'd0, r.first_char[2:0]};
            o.consumed = USED_ONE;
         end else if (!octal_digit(r.third_char)) begin
            o.decoded_byte = {2'd0, r.first_char[2:0], r.second_char[2:0]};
            o.consumed = USED_TWO;
         end else if (oct_value[8]) begin
            o.status = ST_OCT_RANGE;
         end else begin
            o.decoded_byte = oct_value[7:0];
            o.consumed = USED_THREE;
         end
      end else if (r.first_char == "x") begin
         if (!hex_digit(r.second_char)) begin
            o.status = ST_BAD_HEX;
         end else if (!hex_digit(r.third_char)) begin
            o.decoded_byte = {4'd0, hex_weight(r.second_char)};
            o.consumed = USED_TWO;
         end else begin
            o.decoded_byte = {hex_weight(r.second_char), hex_weight(r.third_char)};
            o.consumed = USED_THREE;
         end
      end else if (r.first_char == 8'd0) begin
         o.status = ST_END;
      end else begin
         o.consumed = USED_ONE;
         case (r.first_char)
            "n":     o.decoded_byte = 8'd10;
            "r":     o.decoded_byte = 8'd13;
            "a":     o.decoded_byte = 8'd7;
            "b":     o.decoded_byte = 8'd8;
            "f":     o.decoded_byte = 8'd12;
            "t":     o.decoded_byte = 8'd9;
            "v":     o.decoded_byte = 8'd11;
            default: o.decoded_byte = r.first_char;
         endcase
      end
      return o;
   endfunction

   task automatic report(input string msg);
      fail_count++;
      if (fail_count <= 40) begin
         $display("MISMATCH at %0t: %s", $realtime, msg);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_q.push_back(decode_escape(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               report("result beat with no request outstanding");
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.decoded_byte !== want.decoded_byte) begin
                  report($sformatf("decoded_byte got %h want %h",
                                   rsp_data.decoded_byte, want.decoded_byte));
               end
               if (rsp_data.consumed !== want.consumed) begin
                  report($sformatf("consumed got %0d want %0d",
                                   rsp_data.consumed, want.consumed));
               end
               if (rsp_data.status !== want.status) begin
                  report($sformatf("status got %0d want %0d",
                                   rsp_data.status, want.status));
               end
            end
         end
         results_due = expected_q.size();
      end
   end

endmodule

// File: dv/tb_c_escape_sequence_decoder_unit.sv
// C escape sequence decoder testbench top: clock, reset, request and response
// drivers, watchdog, verdict. Depends on esc_dec_pkg, esc_dec_checker, the unit.
`timescale 1ns / 1ps

module tb_c_escape_sequence_decoder_unit
   import esc_dec_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int BEATS_PER_PHASE = 650;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int fail_count;
   int results_due;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int quiet_cycles = 0;
   logic hold_request = 1'b0;

   c_escape_sequence_decoder_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   esc_dec_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .results_due (results_due)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic req_type seq(input logic [7:0] a, input logic [7:0] b,
                                   input logic [7:0] c);
      req_type r;
      r.first_char = a;
      r.second_char = b;
      r.third_char = c;
      return r;
   endfunction

   function automatic logic [7:0] any_char();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] oct_char();
      return 8'("0" + $urandom_range(0, 7));
   endfunction

   function automatic logic [7:0] hex_char();
      int k;
      k = $urandom_range(0, 21);
      if (k < 10) begin
         return 8'("0" + k);
      end else if (k < 16) begin
         return 8'("a" + k - 10);
      end
      return 8'("A" + k - 16);
   endfunction

   function automatic req_type random_escape();
      int kind;
      logic [7:0] b;
      logic [7:0] c;
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
         b = ($urandom_range(0, 99) < 80) ? oct_char() : any_char();
         c = ($urandom_range(0, 99) < 80) ? oct_char() : any_char();
         return seq(oct_char(), b, c);
      end else if (kind < 55) begin
         b = ($urandom_range(0, 99) < 85) ? hex_char() : any_char();
         c = ($urandom_range(0, 99) < 70) ? hex_char() : any_char();
         return seq("x", b, c);
      end else if (kind < 70) begin
         case ($urandom_range(0, 10))
            0:       b = "n";
            1:       b = "r";
            2:       b = "a";
            3:       b = "b";
            4:       b = "f";
            5:       b = "t";
            6:       b = "v";
            7:       b = "\\";
            8:       b = "'";
            9:       b = "\"";
            default: b = "?";
         endcase
         return seq(b, any_char(), any_char());
      end else if (kind < 75) begin
         return seq(8'd0, any_char(), any_char());
      end
      return seq(any_char(), any_char(), any_char());
   endfunction

   // valid stays up across back-to-back beats; it only drops for an idle gap
   task automatic send_beat(input req_type d);
      if ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < tx_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= d;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (results_due != 0) @(negedge clock);
      @(posedge clock);
   endtask

   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_left = 200;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      tx_idle_pct = 19;
      rx_idle_pct = 64;
      send_beat(seq(8'd0, "1", "2"));
      send_beat(seq("n", "0", "0"));
      send_beat(seq("r", 8'hFF, 8'hFF));
      send_beat(seq("a", "x", "1"));
      send_beat(seq("b", 8'd0, 8'd0));
      send_beat(seq("f", "7", "7"));
      send_beat(seq("t", 8'd0, 8'd0));
      send_beat(seq("v", 8'd0, 8'd0));
      send_beat(seq("\\", "\\", "\\"));
      send_beat(seq("'", 8'd0, 8'd0));
      send_beat(seq("\"", 8'd0, 8'd0));
      send_beat(seq("?", 8'd0, 8'd0));
      send_beat(seq("3", "7", "7"));
      send_beat(seq("4", "0", "0"));
      send_beat(seq("7", "7", "7"));
      send_beat(seq("0", "0", "0"));
      send_beat(seq("0", "8", "1"));
      send_beat(seq("1", "2", "9"));
      send_beat(seq("x", "g", "1"));
      send_beat(seq("x", 8'd0, 8'd0));
      send_beat(seq("x", "f", "F"));
      send_beat(seq("x", "A", "z"));
      send_beat(seq("x", "9", "a"));
      send_beat(seq(8'hFF, 8'hFF, 8'hFF));
      send_beat(seq(8'h80, 8'h00, 8'h00));

      for (int phase = 0; phase < 3; phase++) begin
         tx_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 64 : 0;
         rx_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 19 : 0;
         for (int n = 0; n < BEATS_PER_PHASE; n++) begin
            if (phase == 2 && n == 200) begin
               hold_request = 1'b1;
            end
            send_beat(random_escape());
         end
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (fail_count == 0 && results_due == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
